/* rtl/rwl_pkg.sv */
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and codes for the reader-writer lock arbiter.
// ----------------------------------------------------------------------------
package rwl_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned IdW    = 4;
  localparam int unsigned TmoInW = 16;
  localparam int unsigned EvW    = 3;
  localparam int unsigned CntW   = 5;
  localparam logic [CntW-1:0] ReaderMax = 5'd31;

  typedef enum logic [KindW-1:0] {
    KIND_ENTER_READ  = 3'd0,
    KIND_ENTER_WRITE = 3'd1,
    KIND_EXIT_READ   = 3'd2,
    KIND_EXIT_WRITE  = 3'd3,
    KIND_TICK        = 3'd4
  } kind_e;

  typedef enum logic [EvW-1:0] {
    EV_GRANTED   = 3'd0,
    EV_QUEUED    = 3'd1,
    EV_TIMED_OUT = 3'd2,
    EV_RELEASED  = 3'd3,
    EV_ERROR     = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RGRANT,
    ST_WPOP,
    ST_TICK,
    ST_DONE
  } state_e;

  // one result word from the sequencer to the output stage
  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   who;
    event_e           ev;
    logic             last;
  } res_t;

endpackage

/* rtl/reader_writer_lock_arbiter_unit.sv */
// ----------------------------------------------------------------------------
// reader_writer_lock_arbiter_unit
// Writer-preferring reader-writer lock with reader and writer wait queues.
// ----------------------------------------------------------------------------
// Raise start while busy is low; the word is taken at the rising edge where
// start is high and busy is low. Results come back on valid_o, at most one a
// cycle, with last_o on the final one; for every kind but a tick the first
// comes the cycle after acceptance. They must be taken when shown, since the
// receiver cannot stall. Waking the reader queue grants each waiting reader
// in turn, and granting a waiting writer first shifts the writer queue
// forward. A tick walks the writer queue in a single compact/decrement step,
// dropping expired writers and counting down the timeouts of the rest.
module reader_writer_lock_arbiter_unit #(
  parameter int unsigned MAX_THREADS  = 16,
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned TIMEOUT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  requester_i,
  input  logic [15:0] timeout_ms_i,
  output logic        valid_o,
  output logic [3:0]  who_o,
  output logic [2:0]  event_res_o,
  output logic        last_o
);
  import rwl_pkg::*;

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCW-1:0] QFull = QCW'(QUEUE_DEPTH);
  localparam int unsigned TW = TIMEOUT_BITS;

  logic [IdW-1:0] rq_mem [QUEUE_DEPTH];
  logic [IdW-1:0] wq_id  [QUEUE_DEPTH];
  logic [TW-1:0]  wq_cd  [QUEUE_DEPTH];
  logic           wq_lim [QUEUE_DEPTH];

  state_e         state_q, state_d;
  logic [CntW-1:0] rcnt_q, rcnt_d;
  logic           wact_q, wact_d;
  logic [QCW-1:0] rwc_q, rwc_d, wwc_q, wwc_d;
  logic [QCW-1:0] i_q, i_d, k_q, k_d;
  logic [IdW-1:0] hold_id_q, hold_id_d;
  res_t           res;

  // queue write controls
  logic           rq_we;
  logic [QW-1:0]  rq_wa;
  logic           wq_we;
  logic [QW-1:0]  wq_wa;
  logic [IdW-1:0] wq_wid;
  logic [TW-1:0]  wq_wcd;
  logic           wq_wlim;

  logic [QW-1:0]  ia;
  logic [TW-1:0]  cd_dec;
  logic           expired;
  logic           req_bad;
  logic [TW-1:0]  tmo;

  assign ia      = i_q[QW-1:0];
  assign cd_dec  = (wq_cd[ia] != '0) ? wq_cd[ia] - TW'(1) : wq_cd[ia];
  assign expired = wq_lim[ia] && (cd_dec == '0);
  assign req_bad = 32'(requester_i) >= MAX_THREADS;
  assign tmo     = TW'(timeout_ms_i & 16'((64'd1 << TW) - 64'd1));
  assign busy    = (state_q != ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (rq_we) rq_mem[rq_wa] <= requester_i;
    if (wq_we) begin
      wq_id[wq_wa]  <= wq_wid;
      wq_cd[wq_wa]  <= wq_wcd;
      wq_lim[wq_wa] <= wq_wlim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rcnt_q  <= '0;
      wact_q  <= 1'b0;
      rwc_q   <= '0;
      wwc_q   <= '0;
      i_q     <= '0;
      k_q     <= '0;
      hold_id_q <= '0;
    end else begin
      state_q <= state_d;
      rcnt_q  <= rcnt_d;
      wact_q  <= wact_d;
      rwc_q   <= rwc_d;
      wwc_q   <= wwc_d;
      i_q     <= i_d;
      k_q     <= k_d;
      hold_id_q <= hold_id_d;
    end
  end

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DONE;
          if (!(kind_i > 3'd4 || (kind_i != KIND_TICK && req_bad))) begin
            unique case (kind_e'(kind_i))
              KIND_EXIT_READ: begin
                if (rcnt_q == CntW'(1) && !wact_q && wwc_q != '0) state_d = ST_WPOP;
              end
              KIND_EXIT_WRITE: begin
                if (wact_q) begin
                  if (rwc_q != '0) state_d = ST_RGRANT;
                  else if (wwc_q != '0) state_d = ST_WPOP;
                end
              end
              KIND_TICK: state_d = ST_TICK;
              default: state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_RGRANT: begin
        if (i_q + QCW'(1) >= rwc_q) state_d = ST_DONE;
      end
      ST_WPOP: begin
        if (i_q >= wwc_q) state_d = ST_DONE;
      end
      ST_TICK: begin
        if (i_q >= wwc_q) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer: counters, queue writes and result words
  always_comb begin
    rcnt_d = rcnt_q; wact_d = wact_q; rwc_d = rwc_q; wwc_d = wwc_q;
    i_d = i_q; k_d = k_q; hold_id_d = hold_id_q;
    rq_we = 1'b0; rq_wa = rwc_q[QW-1:0];
    wq_we = 1'b0; wq_wa = wwc_q[QW-1:0];
    wq_wid = requester_i; wq_wcd = tmo; wq_wlim = (tmo != '0);
    res = '{valid: 1'b0, who: requester_i, ev: EV_ERROR, last: 1'b1};
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          res.valid = 1'b1;
          if (kind_i > 3'd4 || (kind_i != KIND_TICK && req_bad)) begin
            res.ev = EV_ERROR;
          end else begin
            unique case (kind_e'(kind_i))
              KIND_ENTER_READ: begin
                if (!wact_q && wwc_q == '0) begin
                  if (rcnt_q >= ReaderMax) res.ev = EV_ERROR;
                  else begin
                    rcnt_d = rcnt_q + CntW'(1);
                    res.ev = EV_GRANTED;
                  end
                end else if (rwc_q >= QFull) res.ev = EV_ERROR;
                else begin
                  rq_we = 1'b1;
                  rwc_d = rwc_q + QCW'(1);
                  res.ev = EV_QUEUED;
                end
              end
              KIND_ENTER_WRITE: begin
                if (rcnt_q == '0 && !wact_q) begin
                  wact_d = 1'b1;
                  res.ev = EV_GRANTED;
                end else if (wwc_q >= QFull) res.ev = EV_ERROR;
                else begin
                  wq_we = 1'b1;
                  wwc_d = wwc_q + QCW'(1);
                  res.ev = EV_QUEUED;
                end
              end
              KIND_EXIT_READ: begin
                if (rcnt_q == '0) res.ev = EV_ERROR;
                else begin
                  rcnt_d = rcnt_q - CntW'(1);
                  res.ev = EV_RELEASED;
                  if (rcnt_q == CntW'(1) && !wact_q && wwc_q != '0) begin
                    res.last = 1'b0;
                    wact_d = 1'b1;
                    hold_id_d = wq_id[0];
                    i_d = QCW'(1);
                  end
                end
              end
              KIND_EXIT_WRITE: begin
                if (!wact_q) res.ev = EV_ERROR;
                else begin
                  wact_d = 1'b0;
                  res.ev = EV_RELEASED;
                  i_d = '0;
                  if (rwc_q != '0) begin
                    res.last = 1'b0;
                  end else if (wwc_q != '0) begin
                    res.last = 1'b0;
                    wact_d = 1'b1;
                    hold_id_d = wq_id[0];
                    i_d = QCW'(1);
                  end
                end
              end
              default: begin
                // tick: walk the writer queue
                res.valid = 1'b0;
                i_d = '0;
                k_d = '0;
              end
            endcase
          end
        end
      end
      ST_RGRANT: begin
        res.valid = 1'b1;
        res.who = rq_mem[ia];
        res.ev = EV_GRANTED;
        res.last = (i_q + QCW'(1) >= rwc_q);
        if (rcnt_q < ReaderMax) rcnt_d = rcnt_q + CntW'(1);
        i_d = i_q + QCW'(1);
        if (res.last) rwc_d = '0;
      end
      ST_WPOP: begin
        // shift one entry forward a cycle, grant when the shift ends
        if (i_q < wwc_q) begin
          wq_we = 1'b1;
          wq_wa = QW'(i_q - QCW'(1));
          wq_wid = wq_id[ia]; wq_wcd = wq_cd[ia]; wq_wlim = wq_lim[ia];
          i_d = i_q + QCW'(1);
        end else begin
          res.valid = 1'b1;
          res.who = hold_id_q;
          res.ev = EV_GRANTED;
          wwc_d = wwc_q - QCW'(1);
        end
      end
      ST_TICK: begin
        if (i_q < wwc_q) begin
          if (expired) begin
            res.valid = 1'b1;
            res.who = wq_id[ia];
            res.ev = EV_TIMED_OUT;
            res.last = 1'b1;
            // is any later entry still to expire? decided by lookahead scan
            for (int j = 0; j < QUEUE_DEPTH; j++) begin
              if (QCW'(j) > i_q && QCW'(j) < wwc_q && wq_lim[j] && wq_cd[j] <= TW'(1))
                res.last = 1'b0;
            end
          end else begin
            wq_we = 1'b1;
            wq_wa = k_q[QW-1:0];
            wq_wid = wq_id[ia]; wq_wcd = cd_dec; wq_wlim = wq_lim[ia];
            k_d = k_q + QCW'(1);
          end
          i_d = i_q + QCW'(1);
        end else begin
          wwc_d = k_q;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  rwl_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .valid_o     (valid_o),
    .who_o       (who_o),
    .event_res_o (event_res_o),
    .last_o      (last_o)
  );

endmodule

/* rtl/rwl_out.sv */
// ----------------------------------------------------------------------------
// rwl_out
// Output register: presents each result word for one cycle with a strobe.
// ----------------------------------------------------------------------------
module rwl_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rwl_pkg::res_t   res_i,
  output logic            valid_o,
  output logic [3:0]      who_o,
  output logic [2:0]      event_res_o,
  output logic            last_o
);
  import rwl_pkg::*;

  logic        valid_q;
  logic [3:0]  who_q;
  logic [2:0]  ev_q;
  logic        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      who_q  <= res_i.who;
      ev_q   <= res_i.ev;
      last_q <= res_i.last;
    end
  end

  assign valid_o     = valid_q;
  assign who_o       = who_q;
  assign event_res_o = ev_q;
  assign last_o      = last_q;

endmodule
